### rtl/core/sphere_box_contact_assert.svh
// Assertion macros shared by the sphere/box contact RTL.
// Every check is sampled on the rising edge of clk and is disabled while rst_n is low.
`ifndef SPHERE_BOX_CONTACT_ASSERT_SVH
`define SPHERE_BOX_CONTACT_ASSERT_SVH
`ifndef SYNTHESIS
`define SBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBC_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SBC_ASSERT(label, prop, msg)
`define SBC_NEVER(label, expr, msg)
`endif
`endif

### rtl/core/sbc_pkg.sv
package sbc_pkg;

    localparam int CW     = 32;
    localparam int RAD_W  = CW - 1;
    localparam int SUM_W  = 2 * CW + 2;
    localparam int LEN_W  = CW + 1;
    localparam int PROD_W = 2 * CW - 1;
    localparam int QUO_W  = CW - 1;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t             sphere_x;
        coord_t             sphere_y;
        coord_t             sphere_z;
        logic [RAD_W-1:0]   sphere_radius;
        coord_t             box_min_x;
        coord_t             box_min_y;
        coord_t             box_min_z;
        coord_t             box_max_x;
        coord_t             box_max_y;
        coord_t             box_max_z;
    } sbc_pair_t;

    typedef struct packed {
        logic               hit;
        logic [CW-1:0]      distance;
        coord_t             depth;
        coord_t             contact_x;
        coord_t             contact_y;
        coord_t             contact_z;
    } sbc_contact_t;

    // Data that rides alongside the square root stages.
    typedef struct packed {
        logic [2:0][CW-1:0]     ctr;
        logic [2:0]             neg;
        logic [RAD_W-1:0]       radius;
        logic                   hit;
        logic [2:0][PROD_W-1:0] prod;
    } sbc_side_a_t;

    // Data that rides alongside the divider stages.
    typedef struct packed {
        logic [2:0][CW-1:0] ctr;
        logic [2:0]         neg;
        logic               len_zero;
        logic [CW-1:0]      dist_sat;
        logic [CW-1:0]      depth;
        logic               hit;
    } sbc_side_b_t;

endpackage

### rtl/core/sbc_sqrt.sv
module sbc_sqrt #(
    parameter int IN_W  = 66,
    parameter int OUT_W = 33
) (
    input  logic             clk,
    input  logic             en,
    input  logic [IN_W-1:0]  radicand,
    output logic [OUT_W-1:0] root
);
    // One root bit is resolved per stage, from the top bit down.
    localparam int TW = 2 * OUT_W + 1;

    logic [TW-1:0]    rem_reg  [OUT_W-1];
    logic [OUT_W-1:0] root_reg [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int B = OUT_W - 1 - k;
        logic [TW-1:0]    rem_i;
        logic [TW-1:0]    trial;
        logic [OUT_W-1:0] root_i;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_i  = TW'(radicand);
            assign root_i = '0;
        end
        else begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign root_i = root_reg[k-1];
        end

        // (root + 2^B)^2 - root^2, with root holding no bits at or below B.
        assign trial = (TW'(root_i) << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = (trial <= rem_i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= take ? (root_i | (OUT_W'(1) << B)) : root_i;
            end
        end

        if (k < OUT_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_i - trial) : rem_i;
                end
            end
        end
    end

    assign root = root_reg[OUT_W-1];

endmodule

### rtl/core/sbc_div.sv
module sbc_div #(
    parameter int N_W = 63,
    parameter int D_W = 33,
    parameter int Q_W = 31
) (
    input  logic           clk,
    input  logic           en,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [Q_W-1:0] quo
);
    // Restoring division, one quotient bit per stage. The quotient must fit in Q_W bits.
    localparam int TW = D_W + Q_W;

    logic [TW-1:0]  rem_reg [Q_W-1];
    logic [D_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0] q_reg   [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [TW-1:0]  rem_i;
        logic [TW-1:0]  trial;
        logic [D_W-1:0] den_i;
        logic [Q_W-1:0] q_i;
        logic           take;

        if (k == 0) begin : g_first
            assign rem_i = TW'(num);
            assign den_i = den;
            assign q_i   = '0;
        end
        else begin : g_next
            assign rem_i = rem_reg[k-1];
            assign den_i = den_reg[k-1];
            assign q_i   = q_reg[k-1];
        end

        assign trial = TW'(den_i) << B;
        assign take  = (trial <= rem_i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k] <= take ? (q_i | (Q_W'(1) << B)) : q_i;
            end
        end

        if (k < Q_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_i - trial) : rem_i;
                    den_reg[k] <= den_i;
                end
            end
        end
    end

    assign quo = q_reg[Q_W-1];

endmodule

### rtl/core/sphere_box_contact.sv
// Sphere versus axis-aligned box contact unit, signed Q16.16 coordinates.
// Input channel: pair_valid / pair_stall / pair carries one item, a sphere
// (center, radius) and a box (min and max corners). Output channel:
// contact_valid / contact_stall / contact carries one item per input item:
// hit flag, distance, penetration depth and contact point.
// An item is taken at a clock edge where valid is high and stall is low.
// The stages are clamp, square, sum, one stage per root bit of the
// pipelined square root (33), a setup stage, one stage per quotient
// bit of the three dividers (31), and the output register.
// Throughput is one item per cycle while the receiver does not stall; every stage holds its own item.
// When the receiver stalls a waiting result, the whole pipeline holds and
// pair_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits, so the pipeline
// comes up empty; the data registers are not reset.
`include "sphere_box_contact_assert.svh"

module sphere_box_contact (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pair_valid,
    output logic                 pair_stall,
    input  sbc_pkg::sbc_pair_t   pair,
    output logic                 contact_valid,
    input  logic                 contact_stall,
    output sbc_pkg::sbc_contact_t contact
);
    import sbc_pkg::*;

    localparam int NST = 3 + LEN_W + 1 + QUO_W + 1;

    // Global advance: everything moves unless the finished item is being held.
    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv           = !(vld_reg[NST-1] && contact_stall);
    assign pair_stall    = !adv;
    assign contact_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], pair_valid};
        end
    end

    // Stage 1: clamp the center into the box and form |closest - center|.
    logic [2:0][CW-1:0] ctr_in, lo_in, hi_in, mag_s1;
    logic [2:0]         neg_s1;

    assign ctr_in[0] = pair.sphere_x;
    assign ctr_in[1] = pair.sphere_y;
    assign ctr_in[2] = pair.sphere_z;
    assign lo_in[0]  = pair.box_min_x;
    assign lo_in[1]  = pair.box_min_y;
    assign lo_in[2]  = pair.box_min_z;
    assign hi_in[0]  = pair.box_max_x;
    assign hi_in[1]  = pair.box_max_y;
    assign hi_in[2]  = pair.box_max_z;

    always_comb
    begin
        logic signed [CW-1:0] c_v, l_v, h_v, p_v;
        logic signed [CW:0]   d_v;
        logic        [CW:0]   m_v;
        for (int i = 0; i < 3; i++)
        begin
            c_v = $signed(ctr_in[i]);
            l_v = $signed(lo_in[i]);
            h_v = $signed(hi_in[i]);
            p_v = (c_v < h_v) ? c_v : h_v;
            // An inverted axis ends up at the lower corner.
            if (p_v < l_v)
            begin
                p_v = l_v;
            end
            d_v = $signed({p_v[CW-1], p_v}) - $signed({c_v[CW-1], c_v});
            neg_s1[i] = d_v[CW];
            m_v = d_v[CW] ? (-d_v) : d_v;
            // The magnitude never exceeds 2^CW - 1, so the top bit is dropped.
            mag_s1[i] = m_v[CW-1:0];
        end
    end

    logic [2:0][CW-1:0] s1_ctr_reg, s1_mag_reg;
    logic [2:0]         s1_neg_reg;
    logic [RAD_W-1:0]   s1_rad_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ctr_reg <= ctr_in;
            s1_mag_reg <= mag_s1;
            s1_neg_reg <= neg_s1;
            s1_rad_reg <= pair.sphere_radius;
        end
    end

    // Stage 2: squares for the length and the hit test, and the scaled offsets.
    logic [2:0][2*CW-1:0]   sq_s2;
    logic [2:0][PROD_W-1:0] prod_s2;
    logic [2*RAD_W-1:0]     rsq_s2;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_s2[i]   = s1_mag_reg[i] * s1_mag_reg[i];
            prod_s2[i] = s1_mag_reg[i] * s1_rad_reg;
        end
        rsq_s2 = s1_rad_reg * s1_rad_reg;
    end

    logic [2:0][2*CW-1:0]   s2_sq_reg;
    logic [2:0][PROD_W-1:0] s2_prod_reg;
    logic [2*RAD_W-1:0]     s2_rsq_reg;
    logic [2:0][CW-1:0]     s2_ctr_reg;
    logic [2:0]             s2_neg_reg;
    logic [RAD_W-1:0]       s2_rad_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sq_reg   <= sq_s2;
            s2_prod_reg <= prod_s2;
            s2_rsq_reg  <= rsq_s2;
            s2_ctr_reg  <= s1_ctr_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_rad_reg  <= s1_rad_reg;
        end
    end

    // Stage 3: exact squared length and the exact hit compare.
    logic [SUM_W-1:0] sum_s3;
    sbc_side_a_t      side_s3;

    always_comb
    begin
        sum_s3 = SUM_W'(s2_sq_reg[0]) + SUM_W'(s2_sq_reg[1]) + SUM_W'(s2_sq_reg[2]);
        side_s3.ctr    = s2_ctr_reg;
        side_s3.neg    = s2_neg_reg;
        side_s3.radius = s2_rad_reg;
        side_s3.hit    = (SUM_W'(s2_rsq_reg) > sum_s3);
        side_s3.prod   = s2_prod_reg;
    end

    logic [SUM_W-1:0] s3_sum_reg;
    sbc_side_a_t      s3_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_sum_reg  <= sum_s3;
            s3_side_reg <= side_s3;
        end
    end

    // Square root, one result bit per stage; side data follows in step.
    logic [LEN_W-1:0] root;
    sbc_side_a_t      side_a_reg [LEN_W];

    sbc_sqrt #(
        .IN_W  (SUM_W),
        .OUT_W (LEN_W)
    ) u_sqrt (
        .clk      (clk),
        .en       (adv),
        .radicand (s3_sum_reg),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_a_reg[0] <= s3_side_reg;
            for (int k = 1; k < LEN_W; k++)
            begin
                side_a_reg[k] <= side_a_reg[k-1];
            end
        end
    end

    // Setup stage: saturate distance and depth, and launch the dividers.
    sbc_side_a_t          sa;
    sbc_side_b_t          side_s4;
    logic signed [CW+1:0] dep_w;

    assign sa = side_a_reg[LEN_W-1];

    always_comb
    begin
        dep_w = $signed({3'b000, sa.radius}) - $signed({1'b0, root});
        side_s4.ctr      = sa.ctr;
        side_s4.neg      = sa.neg;
        side_s4.hit      = sa.hit;
        side_s4.len_zero = (root == '0);
        side_s4.dist_sat = root[LEN_W-1] ? '1 : root[CW-1:0];
        if ((&dep_w[CW+1:CW-1]) || !(|dep_w[CW+1:CW-1]))
        begin
            side_s4.depth = dep_w[CW-1:0];
        end
        else if (dep_w[CW+1])
        begin
            side_s4.depth = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            side_s4.depth = {1'b0, {(CW-1){1'b1}}};
        end
    end

    sbc_side_b_t            s4_side_reg;
    logic [2:0][PROD_W-1:0] s4_prod_reg;
    logic [LEN_W-1:0]       s4_len_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= side_s4;
            s4_prod_reg <= sa.prod;
            s4_len_reg  <= root;
        end
    end

    // Three divider lanes: |d_i| * radius / length, below 2^(CW-1) because |d_i| <= length.
    logic [2:0][QUO_W-1:0] quo;
    sbc_side_b_t           side_b_reg [QUO_W];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        sbc_div #(
            .N_W (PROD_W),
            .D_W (LEN_W),
            .Q_W (QUO_W)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (s4_prod_reg[i]),
            .den (s4_len_reg),
            .quo (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_b_reg[0] <= s4_side_reg;
            for (int k = 1; k < QUO_W; k++)
            begin
                side_b_reg[k] <= side_b_reg[k-1];
            end
        end
    end

    // Output stage: move the center by the signed offset, with saturation.
    // A zero length means the center is inside the box and is reported as is.
    sbc_side_b_t        sb;
    logic [2:0][CW-1:0] cpt;
    sbc_contact_t       contact_next;
    sbc_contact_t       contact_reg;

    assign sb = side_b_reg[QUO_W-1];

    always_comb
    begin
        logic [CW:0] c_e, q_e, s_e;
        for (int i = 0; i < 3; i++)
        begin
            c_e = {sb.ctr[i][CW-1], sb.ctr[i]};
            q_e = {2'b00, quo[i]};
            s_e = sb.neg[i] ? (c_e - q_e) : (c_e + q_e);
            if (sb.len_zero)
            begin
                cpt[i] = sb.ctr[i];
            end
            else if (s_e[CW] == s_e[CW-1])
            begin
                cpt[i] = s_e[CW-1:0];
            end
            else if (s_e[CW])
            begin
                cpt[i] = {1'b1, {(CW-1){1'b0}}};
            end
            else
            begin
                cpt[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
        contact_next.hit       = sb.hit;
        contact_next.distance  = sb.dist_sat;
        contact_next.depth     = sb.depth;
        contact_next.contact_x = cpt[0];
        contact_next.contact_y = cpt[1];
        contact_next.contact_z = cpt[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            contact_reg <= contact_next;
        end
    end

    assign contact = contact_reg;

    // A hit means the floored length is below the radius, so the depth is positive.
    `SBC_ASSERT(a_hit_depth, contact_valid && contact.hit |-> !contact.depth[CW-1] && (contact.depth != '0), "hit with non-positive depth")
    // A miss means the length reaches the radius, so the depth is not positive.
    `SBC_ASSERT(a_miss_depth, contact_valid && !contact.hit |-> contact.depth[CW-1] || (contact.depth == '0), "miss with positive depth")
    // Zero distance gives depth equal to the radius, which is never negative.
    `SBC_NEVER(a_zero_dist, contact_valid && (contact.distance == '0) && contact.depth[CW-1], "negative depth at zero distance")
    // While the output is held, no stage may move.
    `SBC_ASSERT(a_hold, !adv |=> $stable(vld_reg), "pipeline moved during a stall")

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the sphere versus axis-aligned box contact unit.
// A queue of pending pairs is filled by an initial block; a clocked driver
// pushes them into the block in bursts with random gaps. Each accepted pair is
// run through a local contact predictor and its expected contact is queued.
// A clocked monitor compares every accepted contact item field by field with
// the oldest expectation, while the receiver stalls on its own pattern.
module tb_top;
    import sbc_pkg::*;

    localparam int LATENCY   = 69;
    localparam int NUM_RAND  = 1200;
    localparam int MAX_CYCLE = 400000;

    logic          clk;
    logic          rst_n;
    logic          pair_valid;
    logic          pair_stall;
    sbc_pair_t     pair;
    logic          contact_valid;
    logic          contact_stall;
    sbc_contact_t  contact;

    sphere_box_contact dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair_valid    (pair_valid),
        .pair_stall    (pair_stall),
        .pair          (pair),
        .contact_valid (contact_valid),
        .contact_stall (contact_stall),
        .contact       (contact)
    );

    // Stimulus and expectation stores.
    sbc_pair_t    pending_pairs[$];
    sbc_contact_t expected_contacts[$];
    int           mismatches;
    int           cycle_count;
    bit           stim_done;
    bit           hold_sender;
    int           burst_left;
    int           gap_left;
    int           stall_phase;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    // Clamp a signed value to the signed 32-bit range.
    function automatic logic signed [31:0] clamp_coord(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -66'sh0_8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Floor square root of an unsigned 66-bit value, bit by bit.
    function automatic logic [32:0] floor_sqrt(input logic [65:0] s);
        logic [32:0]  r;
        logic [32:0]  cand;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = r | (33'd1 << b);
            if ({33'd0, cand} * {33'd0, cand} <= s)
                r = cand;
        end
        return r;
    endfunction

    function automatic sbc_contact_t predict_contact(input sbc_pair_t p);
        sbc_contact_t        c;
        logic signed [33:0]  ctr[3];
        logic signed [33:0]  lo[3];
        logic signed [33:0]  hi[3];
        logic signed [33:0]  near_pt;
        logic signed [33:0]  diff[3];
        logic [33:0]         mag[3];
        logic [65:0]         sum;
        logic [32:0]         len;
        logic [65:0]         rad;
        logic [65:0]         off;
        logic signed [65:0]  moved;
        logic signed [31:0]  outc[3];
        ctr[0] = p.sphere_x;  ctr[1] = p.sphere_y;  ctr[2] = p.sphere_z;
        lo[0] = p.box_min_x;  lo[1] = p.box_min_y;  lo[2] = p.box_min_z;
        hi[0] = p.box_max_x;  hi[1] = p.box_max_y;  hi[2] = p.box_max_z;
        rad = {35'd0, p.sphere_radius};
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            // Min against the upper corner first, so an inverted axis yields
            // the lower corner.
            near_pt = (ctr[i] < hi[i]) ? ctr[i] : hi[i];
            if (near_pt < lo[i])
                near_pt = lo[i];
            diff[i] = near_pt - ctr[i];
            mag[i] = diff[i] < 0 ? -diff[i] : diff[i];
            sum += {32'd0, mag[i]} * {32'd0, mag[i]};
        end
        len = floor_sqrt(sum);
        c.hit = (rad * rad) > sum;
        c.distance = len[32] ? 32'hFFFF_FFFF : len[31:0];
        c.depth = clamp_coord($signed(rad) - $signed({33'd0, len}));
        for (int i = 0; i < 3; i++)
        begin
            outc[i] = ctr[i][31:0];
            if (len != 0)
            begin
                off = ({32'd0, mag[i]} * rad) / {33'd0, len};
                moved = diff[i] < 0 ? $signed({{32{ctr[i][33]}}, ctr[i]}) - $signed(off)
                                    : $signed({{32{ctr[i][33]}}, ctr[i]}) + $signed(off);
                outc[i] = clamp_coord(moved);
            end
        end
        c.contact_x = outc[0];
        c.contact_y = outc[1];
        c.contact_z = outc[2];
        return c;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic sbc_pair_t rand_pair();
        sbc_pair_t   p;
        logic [31:0] a;
        logic [31:0] b;
        p.sphere_x = rand_coord();
        p.sphere_y = rand_coord();
        p.sphere_z = rand_coord();
        case ($urandom_range(0, 3))
            0:       p.sphere_radius = 31'($urandom);
            1:       p.sphere_radius = '0;
            default: p.sphere_radius = 31'($urandom_range(0, 32'h0006_0000));
        endcase
        // Mostly well-ordered boxes, sometimes inverted axes.
        for (int i = 0; i < 3; i++)
        begin
            a = rand_coord();
            b = rand_coord();
            if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(b))
            begin
                a ^= b; b ^= a; a ^= b;
            end
            case (i)
                0: begin p.box_min_x = a; p.box_max_x = b; end
                1: begin p.box_min_y = a; p.box_max_y = b; end
                default: begin p.box_min_z = a; p.box_max_z = b; end
            endcase
        end
        return p;
    endfunction

    function automatic sbc_pair_t make_pair(input logic [31:0] cx, input logic [31:0] cy,
                                            input logic [31:0] cz, input logic [30:0] r,
                                            input logic [31:0] lo, input logic [31:0] hi);
        sbc_pair_t p;
        p.sphere_x = cx;  p.sphere_y = cy;  p.sphere_z = cz;
        p.sphere_radius = r;
        p.box_min_x = lo; p.box_min_y = lo; p.box_min_z = lo;
        p.box_max_x = hi; p.box_max_y = hi; p.box_max_z = hi;
        return p;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        pair_valid = 1'b0;
        pair = '0;
        contact_stall = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        hold_sender = 1'b0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;

        // Directed pairs: center inside the box, on each face side, at the
        // coordinate extremes, zero and full radius, inverted axes, and a
        // distance large enough to saturate.
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h0001_0000, 32'hFFFF_0000, 32'h0001_0000));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 32'hFFFF_0000, 32'h0001_0000));
        pending_pairs.push_back(make_pair(32'h0003_0000, 0, 0, 31'h0004_0000, 32'hFFFF_0000,
                                          32'h0001_0000));
        pending_pairs.push_back(make_pair(32'hFFFD_0000, 32'h0002_0000, 32'h0005_0000,
                                          31'h0001_0000, 32'hFFFF_0000, 32'h0001_0000));
        pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                          31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                          31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                                          32'h7FFF_FFFF, 32'h8000_0000));
        pending_pairs.push_back(make_pair(0, 0, 0, 31'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000));
        pending_pairs.push_back(make_pair(32'h0002_0000, 0, 0, 31'h0002_0000, 32'hFFFF_0000,
                                          32'h0001_0000));
        pending_pairs.push_back(make_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                          31'h0000_0001, 0, 0));
        pending_pairs.push_back(make_pair(32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_5555,
                                          31'h5555_AAAA, 32'h5555_AAAA, 32'hAAAA_5555));
        for (int i = 0; i < NUM_RAND; i++)
            pending_pairs.push_back(rand_pair());

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Let the first half run, then hold the sender until the pipeline
        // drains completely before releasing the rest.
        wait (pending_pairs.size() < NUM_RAND / 2);
        @(posedge clk);
        hold_sender <= 1'b1;
        wait (expected_contacts.size() == 0 && !pair_valid);
        @(posedge clk);
        hold_sender <= 1'b0;

        wait (pending_pairs.size() == 0 && !pair_valid);
        wait (expected_contacts.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        stim_done = 1'b1;
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Driver: bursts of items separated by random gaps. A held payload only
    // moves on once the block has taken it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pair_valid && !pair_stall)
                expected_contacts.push_back(predict_contact(pair));
            if (!pair_valid || !pair_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    pair_valid <= 1'b0;
                end
                else if (!hold_sender && pending_pairs.size() > 0)
                begin
                    pair <= pending_pairs.pop_front();
                    pair_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    pair_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: quiet stretches alternate with random stalling.
    always @(posedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 300;
        if (!rst_n || stall_phase < 100)
            contact_stall <= 1'b0;
        else if (stall_phase < 200)
            contact_stall <= ($urandom_range(0, 3) == 0);
        else
            contact_stall <= ($urandom_range(0, 1) == 0);
    end

    // Monitor: compare each accepted contact with the oldest expectation.
    always @(posedge clk)
    begin
        sbc_contact_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && contact_valid && !contact_stall)
        begin
            if (expected_contacts.size() == 0)
                report_mismatch("unexpected item", 64'(contact.distance), 64'd0);
            else
            begin
                want = expected_contacts.pop_front();
                if (contact.hit !== want.hit)
                    report_mismatch("hit", 64'(contact.hit), 64'(want.hit));
                if (contact.distance !== want.distance)
                    report_mismatch("distance", 64'(contact.distance), 64'(want.distance));
                if (contact.depth !== want.depth)
                    report_mismatch("depth", 64'(contact.depth), 64'(want.depth));
                if (contact.contact_x !== want.contact_x)
                    report_mismatch("contact_x", 64'(contact.contact_x), 64'(want.contact_x));
                if (contact.contact_y !== want.contact_y)
                    report_mismatch("contact_y", 64'(contact.contact_y), 64'(want.contact_y));
                if (contact.contact_z !== want.contact_z)
                    report_mismatch("contact_z", 64'(contact.contact_z), 64'(want.contact_z));
            end
        end
        if (cycle_count >= MAX_CYCLE && !stim_done)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule
